/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_RST(label, clk, rst_n, !(cond), msg)

`endif

/* rtl/drbl_pkg.sv */
// types and constants of the dram row buffer latency core
`default_nettype none

package drbl_pkg;

    localparam int MAX_BANKS_DEF  = 32;
    localparam int ADDR_WIDTH_DEF = 40;
    localparam int COLUMN_BITS    = 10;

    localparam int BANK_W      = 5;
    localparam int ROW_W       = 30;
    localparam int COL_W       = 10;
    localparam int BYTES_W     = 16;
    localparam int LAT_W       = 20;
    localparam int OUTCOME_W   = 2;
    localparam int BURST_W     = 13;
    localparam int BANK_BITS_W = 3;
    localparam int CYC_W       = 8;
    localparam int SPACING_W   = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [BANK_BITS_W-1:0] BANK_BITS_LIMIT = 3'd5;
    localparam logic [LAT_W-1:0]       LATENCY_MAX     = 20'hFFFFF;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_BANK_BITS      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACT_TO_CAS     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRECHARGE_TIME = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_CAS       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_CAS      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BURST_SPACING  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BURST_BYTES    = 3'd6;

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OUTCOME_HIT      = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_EMPTY    = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_CONFLICT = 2'd2;

    typedef struct packed {
        logic [BANK_BITS_W-1:0] bank_sel_bits;
        logic [CYC_W-1:0]       act_to_cas;
        logic [CYC_W-1:0]       precharge_time;
        logic [CYC_W-1:0]       read_cas_latency;
        logic [CYC_W-1:0]       write_cas_latency;
        logic [SPACING_W-1:0]   burst_spacing;
        logic [BURST_W-1:0]     burst_size;
    } drbl_cfg_t;

    // decoded access waiting for the row table
    typedef struct packed {
        logic               write_access;
        logic [BANK_W-1:0]  bank;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        logic [BYTES_W-1:0] bursts;
    } drbl_entry_t;

endpackage

`default_nettype wire

/* rtl/drbl_queue.sv */
// short queue between the decode front and the row table back
`default_nettype none

module drbl_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  drbl_pkg::drbl_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output drbl_pkg::drbl_entry_t pop_entry,
    output logic                  not_empty
);
    import drbl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    drbl_entry_t      slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/drbl_front.sv */
// front part: takes an item, splits the address and counts bursts
`default_nettype none

module drbl_front #(
    parameter int MAX_BANKS  = drbl_pkg::MAX_BANKS_DEF,
    parameter int ADDR_WIDTH = drbl_pkg::ADDR_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  drbl_pkg::drbl_cfg_t           cfg,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [ADDR_WIDTH-1:0]         addr,
    input  logic                          write_access,
    input  logic [drbl_pkg::BYTES_W-1:0]  byte_count,
    output logic                          push,
    output drbl_pkg::drbl_entry_t         push_entry,
    input  logic                          full
);
    import drbl_pkg::*;

    localparam int DIV_STEPS = BYTES_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam int EXT_W     = ADDR_WIDTH + BANK_W + ROW_W;

    logic                  busy_reg, busy_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [BYTES_W-1:0]    dvd_reg, dvd_next;
    logic [BURST_W-1:0]    rem_reg, rem_next;
    logic                  wr_reg;
    logic [BANK_W-1:0]     bank_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [COL_W-1:0]      col_reg;

    logic                  accept;
    logic                  done;
    logic [BANK_BITS_W-1:0] bb;
    logic [EXT_W-1:0]      addr_ext;
    logic [BANK_W-1:0]     bank_sel_mask;
    logic [BANK_W-1:0]     bank_raw;
    logic [BANK_W-1:0]     bank_dec;
    logic [ROW_W-1:0]      row_dec;
    logic [BURST_W-1:0]    divisor;
    logic [BURST_W:0]      trial;
    logic                  q_bit;

    // address split
    always_comb
    begin
        bb            = (cfg.bank_sel_bits > BANK_BITS_LIMIT) ? BANK_BITS_LIMIT
                                                              : cfg.bank_sel_bits;
        addr_ext      = EXT_W'(addr);
        bank_sel_mask = BANK_W'((6'd1 << bb) - 6'd1);
        bank_raw      = BANK_W'(addr_ext >> COLUMN_BITS) & bank_sel_mask;
        // banks past the populated range fold onto bank 0
        bank_dec      = (6'(bank_raw) >= 6'(MAX_BANKS)) ? '0 : bank_raw;
        row_dec       = ROW_W'(addr_ext >> (COLUMN_BITS + 32'(bb)));
    end

    // one quotient bit per cycle, restoring
    always_comb
    begin
        divisor = (cfg.burst_size == '0) ? BURST_W'(1) : cfg.burst_size;
        trial   = {rem_reg, dvd_reg[BYTES_W-1]};
        q_bit   = (trial >= {1'b0, divisor});
    end

    assign done      = busy_reg && (step_reg == STEP_W'(DIV_STEPS));
    assign push      = done && !full;
    assign req_stall = busy_reg && !push;
    assign accept    = req_valid && !req_stall;

    assign push_entry.write_access = wr_reg;
    assign push_entry.bank         = bank_reg;
    assign push_entry.row          = row_reg;
    assign push_entry.column       = col_reg;
    // ceiling: any remainder costs one more burst
    assign push_entry.bursts       = dvd_reg + BYTES_W'(rem_reg != '0);

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = byte_count;
            rem_next  = '0;
        end
        else if (push)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && !done)
        begin
            step_next = step_reg + 1'b1;
            dvd_next  = {dvd_reg[BYTES_W-2:0], q_bit};
            rem_next  = q_bit ? BURST_W'(trial - {1'b0, divisor}) : BURST_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (accept)
        begin
            wr_reg   <= write_access;
            bank_reg <= bank_dec;
            row_reg  <= row_dec;
            col_reg  <= addr[COLUMN_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/drbl_back.sv */
// back part: open-row lookup, row update and latency sum
`default_nettype none

module drbl_back #(
    parameter int MAX_BANKS = drbl_pkg::MAX_BANKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  drbl_pkg::drbl_cfg_t             cfg,
    input  logic                            not_empty,
    input  drbl_pkg::drbl_entry_t           pop_entry,
    output logic                            pop,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [drbl_pkg::LAT_W-1:0]      latency,
    output logic [drbl_pkg::OUTCOME_W-1:0]  outcome,
    output logic [drbl_pkg::BANK_W-1:0]     bank_index,
    output logic [drbl_pkg::ROW_W-1:0]      row_number,
    output logic [drbl_pkg::COL_W-1:0]      column_number
);
    import drbl_pkg::*;

    localparam int IDX_W = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;

    logic [ROW_W-1:0]     row_table_reg [MAX_BANKS];
    logic [MAX_BANKS-1:0] open_reg, open_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [LAT_W-1:0]     latency_reg;
    logic [OUTCOME_W-1:0] outcome_reg;
    logic [BANK_W-1:0]    bank_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;

    logic [IDX_W-1:0]     idx;
    logic                 is_open;
    logic                 is_hit;
    logic [OUTCOME_W-1:0] outcome_calc;
    logic [CYC_W-1:0]     cas;
    logic [CYC_W+1:0]     base;
    logic [LAT_W-1:0]     burst_cost;
    logic [LAT_W:0]       lat_sum;
    logic [LAT_W-1:0]     lat_calc;

    assign pop = not_empty && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        idx     = IDX_W'(pop_entry.bank);
        is_open = open_reg[idx];
        is_hit  = is_open && (row_table_reg[idx] == pop_entry.row);
        cas     = pop_entry.write_access ? cfg.write_cas_latency : cfg.read_cas_latency;
        priority if (is_hit)
        begin
            outcome_calc = OUTCOME_HIT;
            base         = (CYC_W+2)'(cas);
        end
        else if (!is_open)
        begin
            outcome_calc = OUTCOME_EMPTY;
            base         = (CYC_W+2)'(cas) + (CYC_W+2)'(cfg.act_to_cas);
        end
        else
        begin
            outcome_calc = OUTCOME_CONFLICT;
            base         = (CYC_W+2)'(cas) + (CYC_W+2)'(cfg.act_to_cas)
                         + (CYC_W+2)'(cfg.precharge_time);
        end
        burst_cost = LAT_W'(pop_entry.bursts) * LAT_W'(cfg.burst_spacing);
        lat_sum    = (LAT_W+1)'(burst_cost) + (LAT_W+1)'(base);
        lat_calc   = (lat_sum > (LAT_W+1)'(LATENCY_MAX)) ? LATENCY_MAX : LAT_W'(lat_sum);
    end

    always_comb
    begin
        open_next      = open_reg;
        rsp_valid_next = rsp_valid_reg;
        if (pop)
        begin
            open_next[idx] = 1'b1;
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            open_reg      <= open_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (!is_hit)
            begin
                row_table_reg[idx] <= pop_entry.row;
            end
            latency_reg <= lat_calc;
            outcome_reg <= outcome_calc;
            bank_reg    <= pop_entry.bank;
            row_reg     <= pop_entry.row;
            col_reg     <= pop_entry.column;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign latency       = latency_reg;
    assign outcome       = outcome_reg;
    assign bank_index    = bank_reg;
    assign row_number    = row_reg;
    assign column_number = col_reg;

endmodule

`default_nettype wire

/* rtl/dram_row_buffer_latency_core.sv */
// top level of the dram row buffer latency core
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  req     | req_valid / req_stall   | addr, write_access, byte_count
//  rsp     | rsp_valid / rsp_stall   | latency, outcome, bank_index, row_number,
//          |                         | column_number
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// the front takes no new item until its 16-step burst divider has pushed the last one
// an accepted item passes the burst divider, a queue slot and the back's output registers
// reset clears the open-row flags at once, no clearing pass, cfg_ready stays high
// a two-item queue lets the front keep dividing while rsp_stall holds the back
`default_nettype none

`include "assert_macros.svh"

module dram_row_buffer_latency_core #(
    parameter int MAX_BANKS  = drbl_pkg::MAX_BANKS_DEF,
    parameter int ADDR_WIDTH = drbl_pkg::ADDR_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [ADDR_WIDTH-1:0]              addr,
    input  logic                               write_access,
    input  logic [drbl_pkg::BYTES_W-1:0]       byte_count,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [drbl_pkg::LAT_W-1:0]         latency,
    output logic [drbl_pkg::OUTCOME_W-1:0]     outcome,
    output logic [drbl_pkg::BANK_W-1:0]        bank_index,
    output logic [drbl_pkg::ROW_W-1:0]         row_number,
    output logic [drbl_pkg::COL_W-1:0]         column_number,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [drbl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [drbl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import drbl_pkg::*;

    drbl_cfg_t   cfg_reg, cfg_next;
    drbl_entry_t push_entry;
    drbl_entry_t pop_entry;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_not_empty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BANK_BITS:      cfg_next.bank_sel_bits     = cfg_data[BANK_BITS_W-1:0];
                REG_ACT_TO_CAS:     cfg_next.act_to_cas        = cfg_data[CYC_W-1:0];
                REG_PRECHARGE_TIME: cfg_next.precharge_time    = cfg_data[CYC_W-1:0];
                REG_READ_CAS:       cfg_next.read_cas_latency  = cfg_data[CYC_W-1:0];
                REG_WRITE_CAS:      cfg_next.write_cas_latency = cfg_data[CYC_W-1:0];
                REG_BURST_SPACING:  cfg_next.burst_spacing     = cfg_data[SPACING_W-1:0];
                REG_BURST_BYTES:    cfg_next.burst_size        = cfg_data[BURST_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bank_sel_bits     <= '0;
            cfg_reg.act_to_cas        <= '0;
            cfg_reg.precharge_time    <= '0;
            cfg_reg.read_cas_latency  <= CYC_W'(1);
            cfg_reg.write_cas_latency <= CYC_W'(1);
            cfg_reg.burst_spacing     <= '0;
            cfg_reg.burst_size        <= BURST_W'(64);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    drbl_front #(
        .MAX_BANKS  (MAX_BANKS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .addr         (addr),
        .write_access (write_access),
        .byte_count   (byte_count),
        .push         (q_push),
        .push_entry   (push_entry),
        .full         (q_full)
    );

    drbl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .not_empty  (q_not_empty)
    );

    drbl_back #(
        .MAX_BANKS (MAX_BANKS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .not_empty     (q_not_empty),
        .pop_entry     (pop_entry),
        .pop           (q_pop),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .latency       (latency),
        .outcome       (outcome),
        .bank_index    (bank_index),
        .row_number    (row_number),
        .column_number (column_number)
    );

    `ASSERT_NEVER(a_pop_empty, clk, rst_n, q_pop && !q_not_empty, "pop from empty queue")
    `ASSERT_NEVER(a_push_full, clk, rst_n, q_push && q_full, "push into full queue")
    `ASSERT_RST(a_bank_range, clk, rst_n, rsp_valid |-> (6'(bank_index) < 6'(MAX_BANKS)), "bank out of range")
    `ASSERT_RST(a_rsp_follows_pop, clk, rst_n, (q_pop && !rsp_valid) |=> rsp_valid, "popped item not shown")

endmodule

`default_nettype wire

/* test/tb_dram_row_buffer_latency_core.sv */
// self-checking testbench for the dram row buffer latency core
`timescale 1ns / 1ps

module tb_dram_row_buffer_latency_core;

    import drbl_pkg::*;

    localparam int ADDR_W = ADDR_WIDTH_DEF;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [ADDR_W-1:0]  addr;
        logic               write_access;
        logic [BYTES_W-1:0] byte_count;
    } access_t;

    typedef struct {
        logic [LAT_W-1:0]     latency;
        logic [OUTCOME_W-1:0] outcome;
        logic [BANK_W-1:0]    bank;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     column;
    } timing_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic [ADDR_W-1:0]      addr = '0;
    logic                   write_access = 1'b0;
    logic [BYTES_W-1:0]     byte_count = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    logic [LAT_W-1:0]       latency;
    logic [OUTCOME_W-1:0]   outcome;
    logic [BANK_W-1:0]      bank_index;
    logic [ROW_W-1:0]       row_number;
    logic [COL_W-1:0]       column_number;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state: register copy and open-row table
    drbl_cfg_t        model_cfg = '{bank_sel_bits: '0, act_to_cas: '0, precharge_time: '0,
                                    read_cas_latency: 8'd1, write_cas_latency: 8'd1,
                                    burst_spacing: '0, burst_size: 13'd64};
    logic [ROW_W-1:0] held_row [MAX_BANKS_DEF];
    logic [MAX_BANKS_DEF-1:0] row_open = '0;

    access_t access_q [$];
    timing_t predicted_timing [$];
    access_t offered;
    int      mismatches = 0;

    // idling knobs, changed only between phases
    int unsigned burst_max = 4;
    int unsigned gap_max = 6;
    int unsigned stall_max = 5;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned free_left = 0;

    dram_row_buffer_latency_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .addr          (addr),
        .write_access  (write_access),
        .byte_count    (byte_count),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .latency       (latency),
        .outcome       (outcome),
        .bank_index    (bank_index),
        .row_number    (row_number),
        .column_number (column_number),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic timing_t row_buffer_lookup(access_t acc);
        timing_t           t;
        int unsigned       bb;
        logic [ADDR_W-1:0] above;
        logic [ADDR_W-1:0] shifted;
        logic [31:0]       bank_sel_mask;
        longint unsigned   cas;
        longint unsigned   cycles;
        longint unsigned   span;
        longint unsigned   bursts;
        bb = (model_cfg.bank_sel_bits > BANK_BITS_LIMIT) ? BANK_BITS_LIMIT
                                                         : model_cfg.bank_sel_bits;
        above = acc.addr >> COLUMN_BITS;
        shifted = above >> bb;
        bank_sel_mask = (32'd1 << bb) - 32'd1;
        t.column = acc.addr[COL_W-1:0];
        // five bank bits at most, so the bank never reaches MAX_BANKS
        t.bank = above[BANK_W-1:0] & bank_sel_mask[BANK_W-1:0];
        t.row = shifted[ROW_W-1:0];
        cas = acc.write_access ? model_cfg.write_cas_latency : model_cfg.read_cas_latency;
        if (row_open[t.bank] && held_row[t.bank] == t.row)
        begin
            t.outcome = OUTCOME_HIT;
            cycles = cas;
        end
        else if (!row_open[t.bank])
        begin
            t.outcome = OUTCOME_EMPTY;
            cycles = model_cfg.act_to_cas + cas;
            held_row[t.bank] = t.row;
            row_open[t.bank] = 1'b1;
        end
        else
        begin
            t.outcome = OUTCOME_CONFLICT;
            cycles = model_cfg.precharge_time + model_cfg.act_to_cas + cas;
            held_row[t.bank] = t.row;
        end
        span = (model_cfg.burst_size == 0) ? 1 : model_cfg.burst_size;
        bursts = (longint'(acc.byte_count) + span - 1) / span;
        cycles += bursts * model_cfg.burst_spacing;
        if (cycles > LATENCY_MAX)
        begin
            cycles = LATENCY_MAX;
        end
        t.latency = LAT_W'(cycles);
        return t;
    endfunction

    function automatic logic [ADDR_W-1:0] compose_addr(logic [ROW_W-1:0] row, int unsigned bank,
                                                       logic [COL_W-1:0] col, int unsigned bb);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(row) << (COLUMN_BITS + bb);
        a = a | (ADDR_W'(bank) << COLUMN_BITS) | ADDR_W'(col);
        return a;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_timing(int unsigned top);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return CFG_DATA_W'(top);
            2: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(1, 20));
        endcase
    endfunction

    task automatic queue_access(input logic [ADDR_W-1:0] a, input logic wr,
                                input logic [BYTES_W-1:0] n);
        access_q.push_back('{a, wr, n});
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_BANK_BITS:      model_cfg.bank_sel_bits = data[BANK_BITS_W-1:0];
            REG_ACT_TO_CAS:     model_cfg.act_to_cas = data[CYC_W-1:0];
            REG_PRECHARGE_TIME: model_cfg.precharge_time = data[CYC_W-1:0];
            REG_READ_CAS:       model_cfg.read_cas_latency = data[CYC_W-1:0];
            REG_WRITE_CAS:      model_cfg.write_cas_latency = data[CYC_W-1:0];
            REG_BURST_SPACING:  model_cfg.burst_spacing = data[SPACING_W-1:0];
            REG_BURST_BYTES:    model_cfg.burst_size = data[BURST_W-1:0];
            default:            ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // sender holds off until every predicted timing has come back
    task automatic wait_drain();
        while (access_q.size() != 0 || req_valid || predicted_timing.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (25) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predicted_timing.push_back(row_buffer_lookup(offered));
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (access_q.size() > 0)
                begin
                    offered = access_q.pop_front();
                    req_valid <= 1'b1;
                    addr <= offered.addr;
                    write_access <= offered.write_access;
                    byte_count <= offered.byte_count;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, burst_max);
                    end
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        gap_left = $urandom_range(0, gap_max);
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response stall pattern: free runs alternating with stall runs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left = 0;
            free_left = 0;
        end
        else if (free_left > 0)
        begin
            free_left--;
            rsp_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            free_left = $urandom_range(0, 40);
            stall_left = (stall_max == 0) ? 0 : $urandom_range(1, stall_max);
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        timing_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (predicted_timing.size() == 0)
            begin
                $display("%0t ns: response with no access outstanding, expected none got %0h",
                         $time, latency);
                mismatches++;
            end
            else
            begin
                want = predicted_timing.pop_front();
                check_field("latency", want.latency, latency);
                check_field("outcome", want.outcome, outcome);
                check_field("bank_index", want.bank, bank_index);
                check_field("row_number", want.row, row_number);
                check_field("column_number", want.column, column_number);
            end
        end
    end

    initial
    begin
        int                 p;
        int                 n;
        int unsigned        eff_bb;
        logic [ROW_W-1:0]   row_pool [4];
        logic [ADDR_W-1:0]  a;
        logic [BYTES_W-1:0] bytes;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one bank, a row of all ones must still hit
        queue_access(compose_addr(0, 0, 0, 0), 1'b0, 16'd0);
        queue_access(compose_addr(0, 0, 10'h3FF, 0), 1'b1, 16'd1);
        queue_access(40'hFF_FFFF_FFFF, 1'b0, 16'hFFFF);
        queue_access(40'hFF_FFFF_FFFF, 1'b1, 16'd64);
        queue_access(compose_addr(30'h3FFFFFFF, 0, 0, 0), 1'b0, 16'd65);
        queue_access(compose_addr(1, 0, 5, 0), 1'b1, 16'd128);
        queue_access(compose_addr(1, 0, 5, 0), 1'b0, 16'd63);
        wait_drain();

        // extremes: too many bank bits with junk above, zero burst size
        write_reg(REG_BANK_BITS, 13'h1FFF);
        write_reg(REG_ACT_TO_CAS, 13'd255);
        write_reg(REG_PRECHARGE_TIME, 13'd255);
        write_reg(REG_READ_CAS, 13'd255);
        write_reg(REG_WRITE_CAS, 13'd0);
        write_reg(REG_BURST_SPACING, 13'd15);
        write_reg(REG_BURST_BYTES, 13'd0);
        write_reg(REG_UNUSED, 13'h1555);
        queue_access(40'hFF_FFFF_FFFF, 1'b0, 16'd1);
        queue_access(40'hFF_FFFF_FFFF, 1'b1, 16'hFFFF);
        queue_access(compose_addr(0, 31, 0, 5), 1'b0, 16'd0);
        queue_access(compose_addr(0, 0, 0, 5), 1'b1, 16'd0);
        queue_access(compose_addr(0, 0, 10'h3FF, 5), 1'b1, 16'hFFFF);
        queue_access(compose_addr(30'h3FFFFFFF, 0, 0, 5), 1'b0, 16'd2);
        wait_drain();

        write_reg(REG_BANK_BITS, 13'd6);
        write_reg(REG_ACT_TO_CAS, 13'd0);
        write_reg(REG_PRECHARGE_TIME, 13'd0);
        write_reg(REG_READ_CAS, 13'd0);
        write_reg(REG_WRITE_CAS, 13'd255);
        write_reg(REG_BURST_SPACING, 13'd1);
        write_reg(REG_BURST_BYTES, 13'd4096);
        queue_access(compose_addr(5, 17, 3, 5), 1'b0, 16'd4096);
        queue_access(compose_addr(5, 17, 3, 5), 1'b1, 16'd4097);
        queue_access(compose_addr(6, 17, 0, 5), 1'b0, 16'hFFFF);
        wait_drain();

        write_reg(REG_BANK_BITS, 13'd1);
        write_reg(REG_BURST_BYTES, 13'd1);
        write_reg(REG_BURST_SPACING, 13'd15);
        queue_access(compose_addr(7, 1, 0, 1), 1'b1, 16'hFFFF);
        queue_access(compose_addr(7, 1, 10'h2AA, 1), 1'b0, 16'h5555);
        wait_drain();

        for (p = 0; p < 12; p++)
        begin
            case (p % 4)
                0:
                begin
                    burst_max = 1000;
                    gap_max = 0;
                    stall_max = 0;
                end
                1:
                begin
                    burst_max = 8;
                    gap_max = 30;
                    stall_max = 3;
                end
                2:
                begin
                    burst_max = 30;
                    gap_max = 5;
                    stall_max = 40;
                end
                default:
                begin
                    burst_max = 3;
                    gap_max = 20;
                    stall_max = 20;
                end
            endcase
            write_reg(REG_BANK_BITS, $urandom_range(0, 1) ? 13'($urandom)
                                                         : 13'($urandom_range(0, 7)));
            write_reg(REG_ACT_TO_CAS, pick_timing(255));
            write_reg(REG_PRECHARGE_TIME, pick_timing(255));
            write_reg(REG_READ_CAS, pick_timing(255));
            write_reg(REG_WRITE_CAS, pick_timing(255));
            write_reg(REG_BURST_SPACING, pick_timing(15));
            write_reg(REG_BURST_BYTES, pick_timing(4096));
            write_reg(REG_UNUSED, 13'($urandom));

            eff_bb = (model_cfg.bank_sel_bits > BANK_BITS_LIMIT) ? BANK_BITS_LIMIT
                                                                 : model_cfg.bank_sel_bits;
            // a few rows per phase so hits and conflicts both come up often
            row_pool[0] = '0;
            row_pool[1] = '1;
            row_pool[2] = ROW_W'($urandom);
            row_pool[3] = ROW_W'($urandom);
            for (n = 0; n < 95; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    a = ADDR_W'({$urandom, $urandom});
                end
                else
                begin
                    a = compose_addr(row_pool[$urandom_range(0, 3)],
                                     $urandom_range(0, (1 << eff_bb) - 1),
                                     COL_W'($urandom), eff_bb);
                end
                case ($urandom_range(0, 7))
                    0: bytes = '0;
                    1: bytes = '1;
                    2, 3: bytes = BYTES_W'($urandom);
                    default: bytes = BYTES_W'($urandom_range(1, 300));
                endcase
                queue_access(a, 1'($urandom_range(0, 1)), bytes);
            end
            wait_drain();
        end

        if (mismatches == 0 && predicted_timing.size() == 0)
        begin
            $display("dram_row_buffer_latency_core verification clean");
        end
        else
        begin
            $display("dram_row_buffer_latency_core verification failed");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("dram_row_buffer_latency_core verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/drbl_pkg.sv
rtl/drbl_queue.sv
rtl/drbl_front.sv
rtl/drbl_back.sv
rtl/dram_row_buffer_latency_core.sv
test/tb_dram_row_buffer_latency_core.sv
